// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hss_pkg.sv =====
// types, constants and period arithmetic for the half-step stepper sequencer
`default_nettype none

package hss_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int STEP_COUNT_BITS = 16;
  localparam int SETTLE_BITS     = 10;
  localparam int TICK_BITS       = 11;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = (SAMPLE_BITS > SETTLE_BITS) ? SAMPLE_BITS : SETTLE_BITS;
  // dividend of the divide-by-full-scale unit, and the jog product before halving
  localparam int DIV_IN_BITS     = SAMPLE_BITS + 11;
  localparam int PROD_BITS       = DIV_IN_BITS + 1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;
  localparam logic [9:0]  CMD_SCALE = 10'd499;
  localparam logic [11:0] JOG_SCALE = 12'd2495;

  // register reset values
  localparam logic [SETTLE_BITS-1:0] SETTLE_RESET  = SETTLE_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] FWD_ON_RESET  = SAMPLE_BITS'(2458);
  localparam logic [SAMPLE_BITS-1:0] FWD_OFF_RESET = SAMPLE_BITS'(2376);
  localparam logic [SAMPLE_BITS-1:0] REV_ON_RESET  = SAMPLE_BITS'(1638);
  localparam logic [SAMPLE_BITS-1:0] REV_OFF_RESET = SAMPLE_BITS'(1720);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_ABORT = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MANUAL_MODE  = 3'd0,
    REG_SETTLE_TICKS = 3'd1,
    REG_FWD_ON       = 3'd2,
    REG_FWD_OFF      = 3'd3,
    REG_REV_ON       = 3'd4,
    REG_REV_OFF      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    IND_COMMAND    = 2'd0,
    IND_MANUAL_OFF = 2'd1,
    IND_MANUAL_ON  = 2'd2
  } indicator_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MOVING   = 5'b00010,
    ST_SETTLING = 5'b00100,
    ST_JOG_FWD  = 5'b01000,
    ST_JOG_REV  = 5'b10000
  } run_state_t;

  typedef struct packed {
    logic [1:0]                 action;
    logic                       direction;
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic [SAMPLE_BITS-1:0]     speed_sample;
    logic [SAMPLE_BITS-1:0]     joy_sample;
    logic                       jog_enabled;
  } item_t;

  typedef struct packed {
    logic [3:0]                 coils;
    logic                       busy_res;
    logic                       jogging;
    logic [STEP_COUNT_BITS-1:0] steps_left;
    logic [1:0]                 indicator;
  } result_t;

  // half-step coil table, bit3 A, bit2 B, bit1 A_, bit0 B_
  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] c;
    unique case (phase)
      3'd0:    c = 4'b1000;
      3'd1:    c = 4'b1100;
      3'd2:    c = 4'b0100;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0010;
      3'd5:    c = 4'b0011;
      3'd6:    c = 4'b0001;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

  // floor(x / (2^SAMPLE_BITS - 1)) by folding the high part back twice
  function automatic logic [TICK_BITS-1:0] div_full(input logic [DIV_IN_BITS-1:0] x);
    logic [DIV_IN_BITS-1:0] q0;
    logic [DIV_IN_BITS-1:0] r0;
    logic [DIV_IN_BITS-1:0] q1;
    logic [DIV_IN_BITS-1:0] r1;
    logic [DIV_IN_BITS-1:0] q;
    q0 = x >> SAMPLE_BITS;
    r0 = DIV_IN_BITS'(x[SAMPLE_BITS-1:0]) + q0;
    q1 = r0 >> SAMPLE_BITS;
    r1 = DIV_IN_BITS'(r0[SAMPLE_BITS-1:0]) + q1;
    q  = q0 + q1 + DIV_IN_BITS'(r1 >= DIV_IN_BITS'(SAMPLE_FULL));
    return q[TICK_BITS-1:0];
  endfunction

  // commanded phase length: 1 + 499 * s / full
  function automatic logic [TICK_BITS-1:0] cmd_period(input logic [SAMPLE_BITS-1:0] s);
    logic [DIV_IN_BITS-1:0] p;
    p = DIV_IN_BITS'(s) * DIV_IN_BITS'(CMD_SCALE);
    return div_full(p) + TICK_BITS'(1);
  endfunction

  // jog phase length: 1 + 1247.5 * z / full, z = y backward or full - y forward
  function automatic logic [TICK_BITS-1:0] jog_period(input logic [SAMPLE_BITS-1:0] z);
    logic [PROD_BITS-1:0] p;
    p = PROD_BITS'(z) * PROD_BITS'(JOG_SCALE);
    return div_full(p[PROD_BITS-1:1]) + TICK_BITS'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/half_step_stepper_sequencer_unit.sv =====
// Half-step stepper sequencer: one result per transaction, carried through an input register
// and then a result register; one transaction per cycle sustained while out_ready holds;
// phase periods are worked out ahead of the input register. Synchronous reset clears
// control state and out_valid and loads register defaults (command mode, settle 100
// ticks, default jog levels); the result register itself is not reset.
`default_nettype none

module half_step_stepper_sequencer_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  hss_pkg::item_t               in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output hss_pkg::result_t                   out_data,
  input  wire                                cfg_we,
  input  wire  [hss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [hss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  typedef struct packed {
    hss_pkg::item_t                  item;
    logic [hss_pkg::TICK_BITS-1:0]   cmd_per;
    logic [hss_pkg::TICK_BITS-1:0]   fwd_per;
    logic [hss_pkg::TICK_BITS-1:0]   rev_per;
  } stage_t;

  // configuration registers
  logic                                manual_mode;
  logic [hss_pkg::SETTLE_BITS-1:0]     settle_ticks;
  logic [hss_pkg::SAMPLE_BITS-1:0]     fwd_on_level;
  logic [hss_pkg::SAMPLE_BITS-1:0]     fwd_off_level;
  logic [hss_pkg::SAMPLE_BITS-1:0]     rev_on_level;
  logic [hss_pkg::SAMPLE_BITS-1:0]     rev_off_level;

  // sequencer state
  hss_pkg::run_state_t                 run_state, run_state_next;
  logic [2:0]                          phase_index, phase_index_next;
  logic                                move_direction, move_direction_next;
  logic [hss_pkg::STEP_COUNT_BITS-1:0] remaining_steps, remaining_steps_next;
  logic [hss_pkg::TICK_BITS-1:0]       tick_counter, tick_counter_next;

  // pipeline
  logic                                stage_valid;
  stage_t                              stage;
  logic                                out_load;
  logic                                mode_flip;
  hss_pkg::result_t                    result_next;
  logic [hss_pkg::TICK_BITS-1:0]       tdec;

  assign out_load = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || out_load;
  assign mode_flip = cfg_we && (cfg_index == hss_pkg::REG_MANUAL_MODE)
                     && (cfg_data[0] != manual_mode);

  // input register, periods computed from the incoming samples
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.item    <= in_data;
      stage.cmd_per <= hss_pkg::cmd_period(in_data.speed_sample);
      stage.fwd_per <= hss_pkg::jog_period(~in_data.joy_sample);
      stage.rev_per <= hss_pkg::jog_period(in_data.joy_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (out_load) begin
      stage_valid <= 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode   <= 1'b0;
      settle_ticks  <= hss_pkg::SETTLE_RESET;
      fwd_on_level  <= hss_pkg::FWD_ON_RESET;
      fwd_off_level <= hss_pkg::FWD_OFF_RESET;
      rev_on_level  <= hss_pkg::REV_ON_RESET;
      rev_off_level <= hss_pkg::REV_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hss_pkg::REG_MANUAL_MODE:  manual_mode   <= cfg_data[0];
        hss_pkg::REG_SETTLE_TICKS: settle_ticks  <= cfg_data[hss_pkg::SETTLE_BITS-1:0];
        hss_pkg::REG_FWD_ON:       fwd_on_level  <= cfg_data[hss_pkg::SAMPLE_BITS-1:0];
        hss_pkg::REG_FWD_OFF:      fwd_off_level <= cfg_data[hss_pkg::SAMPLE_BITS-1:0];
        hss_pkg::REG_REV_ON:       rev_on_level  <= cfg_data[hss_pkg::SAMPLE_BITS-1:0];
        hss_pkg::REG_REV_OFF:      rev_off_level <= cfg_data[hss_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // next state for the transaction in the input register
  always_comb begin
    run_state_next       = run_state;
    phase_index_next     = phase_index;
    move_direction_next  = move_direction;
    remaining_steps_next = remaining_steps;
    tick_counter_next    = tick_counter;
    tdec                 = tick_counter - hss_pkg::TICK_BITS'(tick_counter != '0);

    case (stage.item.action)
      hss_pkg::ACT_ABORT: begin
        run_state_next       = hss_pkg::ST_IDLE;
        remaining_steps_next = '0;
        tick_counter_next    = '0;
      end
      hss_pkg::ACT_START: begin
        if (!manual_mode && run_state == hss_pkg::ST_IDLE && stage.item.step_count != '0) begin
          move_direction_next  = stage.item.direction;
          phase_index_next     = stage.item.direction ? 3'd7 : 3'd0;
          remaining_steps_next = stage.item.step_count - hss_pkg::STEP_COUNT_BITS'(1);
          tick_counter_next    = stage.cmd_per;
          run_state_next       = hss_pkg::ST_MOVING;
        end
      end
      hss_pkg::ACT_TICK: begin
        if (!manual_mode) begin
          // commanded move and settle countdown
          priority case (run_state)
            hss_pkg::ST_MOVING: begin
              tick_counter_next = tdec;
              if (tdec == '0) begin
                if (remaining_steps != '0) begin
                  phase_index_next     = phase_index + (move_direction ? 3'd7 : 3'd1);
                  remaining_steps_next = remaining_steps - hss_pkg::STEP_COUNT_BITS'(1);
                  tick_counter_next    = stage.cmd_per;
                end else if (settle_ticks == '0) begin
                  run_state_next       = hss_pkg::ST_IDLE;
                  remaining_steps_next = '0;
                  tick_counter_next    = '0;
                end else begin
                  run_state_next    = hss_pkg::ST_SETTLING;
                  tick_counter_next = hss_pkg::TICK_BITS'(settle_ticks);
                end
              end
            end
            hss_pkg::ST_SETTLING: begin
              tick_counter_next = tdec;
              if (tdec == '0) begin
                run_state_next       = hss_pkg::ST_IDLE;
                remaining_steps_next = '0;
              end
            end
            default: begin
              run_state_next       = hss_pkg::ST_IDLE;
              remaining_steps_next = '0;
              tick_counter_next    = '0;
            end
          endcase
        end else begin
          // joystick jog with hysteresis
          if (run_state == hss_pkg::ST_MOVING || run_state == hss_pkg::ST_SETTLING ||
              !stage.item.jog_enabled ||
              (run_state == hss_pkg::ST_JOG_FWD && stage.item.joy_sample < fwd_off_level) ||
              (run_state == hss_pkg::ST_JOG_REV && stage.item.joy_sample > rev_off_level)) begin
            run_state_next       = hss_pkg::ST_IDLE;
            remaining_steps_next = '0;
            tick_counter_next    = '0;
          end
          if (stage.item.jog_enabled) begin
            if (run_state_next == hss_pkg::ST_JOG_FWD || run_state_next == hss_pkg::ST_JOG_REV) begin
              tick_counter_next = tdec;
              if (tdec == '0) begin
                phase_index_next  = phase_index + (move_direction ? 3'd7 : 3'd1);
                tick_counter_next = move_direction ? stage.rev_per : stage.fwd_per;
              end
            end else if (stage.item.joy_sample >= fwd_on_level) begin
              move_direction_next  = 1'b0;
              phase_index_next     = 3'd0;
              run_state_next       = hss_pkg::ST_JOG_FWD;
              remaining_steps_next = '0;
              tick_counter_next    = stage.fwd_per;
            end else if (stage.item.joy_sample <= rev_on_level) begin
              move_direction_next  = 1'b1;
              phase_index_next     = 3'd7;
              run_state_next       = hss_pkg::ST_JOG_REV;
              remaining_steps_next = '0;
              tick_counter_next    = stage.rev_per;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result for the transaction, taken from the updated state
  always_comb begin
    result_next.coils      = (run_state_next == hss_pkg::ST_IDLE) ? 4'b0000
                             : hss_pkg::coil_pattern(phase_index_next);
    result_next.busy_res   = (run_state_next == hss_pkg::ST_MOVING) ||
                             (run_state_next == hss_pkg::ST_SETTLING);
    result_next.jogging    = (run_state_next == hss_pkg::ST_JOG_FWD) ||
                             (run_state_next == hss_pkg::ST_JOG_REV);
    result_next.steps_left = (run_state_next == hss_pkg::ST_MOVING) ? remaining_steps_next : '0;
    result_next.indicator  = !manual_mode ? hss_pkg::IND_COMMAND
                             : (stage.item.jog_enabled ? hss_pkg::IND_MANUAL_ON
                                                       : hss_pkg::IND_MANUAL_OFF);
  end

  // state registers, a mode change drops any activity
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state       <= hss_pkg::ST_IDLE;
      phase_index     <= 3'd0;
      move_direction  <= 1'b0;
      remaining_steps <= '0;
      tick_counter    <= '0;
    end else if (mode_flip) begin
      run_state       <= hss_pkg::ST_IDLE;
      remaining_steps <= '0;
      tick_counter    <= '0;
    end else if (out_load) begin
      run_state       <= run_state_next;
      phase_index     <= phase_index_next;
      move_direction  <= move_direction_next;
      remaining_steps <= remaining_steps_next;
      tick_counter    <= tick_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/hss_checker.sv =====
// port-level checks for the half-step stepper sequencer, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module hss_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire hss_pkg::result_t out_data
);

  // a stalled result transaction holds its payload
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // coils are driven exactly when a move, settle or jog is active
  `ASSERT_CLK(a_coils_active, out_valid |-> ((out_data.coils != 4'b0000) == (out_data.busy_res || out_data.jogging)), "coil drive disagrees with activity")

  // a commanded move and a jog never coexist, and steps only count during a move or its settle
  `ASSERT_CLK(a_mode_exclusive, out_valid |-> !(out_data.busy_res && out_data.jogging) && (out_data.steps_left == '0 || out_data.busy_res), "activity flags inconsistent")

  // jogging only in manual mode, commanded moves only in command mode
  `ASSERT_CLK(a_indicator, out_valid |-> (!out_data.jogging || out_data.indicator != hss_pkg::IND_COMMAND) && (!out_data.busy_res || out_data.indicator == hss_pkg::IND_COMMAND), "activity in the wrong mode")

  // no result right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind half_step_stepper_sequencer_unit hss_checker u_hss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
